/* sv/rotation_matrix_to_quaternion_macros.svh */
// assertion macros for the rotation matrix to quaternion block
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`ifndef SYNTHESIS
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RMQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/rmq_pkg.sv */
// shared types, widths and codes of the rotation matrix to quaternion block
package rmq_pkg;

    localparam int F = 14;
    localparam int ONE = 2 ** F;
    localparam int CW = ((F > 15) ? F : 15) + 3;
    localparam int NW = CW;
    localparam int SW = 2 * CW;
    localparam int MW = 2 * CW - 2;
    localparam int RW = NW + 3;
    localparam int DW = CW + F;
    localparam int QW = F + 1;
    localparam int KW = ((CW + F) > 34) ? (CW + F) : 34;
    localparam int EW = 15;
    localparam logic [EW-1:0] EPS_RESET = EW'(16);

    localparam logic [2:0] BR_TRACE = 3'd0;
    localparam logic [2:0] BR_XDOM  = 3'd1;
    localparam logic [2:0] BR_YDOM  = 3'd2;
    localparam logic [2:0] BR_ZDOM  = 3'd3;
    localparam logic [2:0] BR_IDENT = 3'd4;

    typedef struct packed {
        logic signed [15:0] el_00;
        logic signed [15:0] el_01;
        logic signed [15:0] el_02;
        logic signed [15:0] el_10;
        logic signed [15:0] el_11;
        logic signed [15:0] el_12;
        logic signed [15:0] el_20;
        logic signed [15:0] el_21;
        logic signed [15:0] el_22;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic [2:0]         branch_taken;
    } out_word_t;

    typedef struct packed {
        logic [3:0]             neg;
        logic [3:0][CW-2:0]     mag;
        logic [2:0]             branch;
    } carry_t;

endpackage

/* sv/rotation_matrix_to_quaternion.sv */
// rotation matrix to unit quaternion, top level
// an accepted input word passes stages 1 to 4, the root and divider pipelines and the output register
// throughput: one word per cycle while the output skid is empty; the root and divider pipelines take one bit per stage
// a one-word output skid takes the word that meets a stall; input closes while it is full
// reset: asynchronous active low, clears valid bits; threshold returns to 16
// a threshold write is registered in eps_reg; the squared threshold in thr_sq_reg is registered from it
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rmq_pkg::in_word_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rmq_pkg::out_word_t    out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [rmq_pkg::EW-1:0] cfg_data
);

    localparam int CW = rmq_pkg::CW;
    localparam logic signed [CW-1:0] ONE_S = CW'(rmq_pkg::ONE);

    logic                   en;
    logic [rmq_pkg::EW-1:0] eps_reg;
    logic [33:0]            thr_sq_reg;
    logic [16:0]            thr_t;

    assign cfg_ready = 1'b1;
    assign thr_t     = {1'b0, eps_reg, 1'b0} + 17'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg    <= rmq_pkg::EPS_RESET;
            thr_sq_reg <= 34'd1156;
        end
        else
        begin
            if (cfg_valid)
            begin
                eps_reg <= cfg_data;
            end
            thr_sq_reg <= 34'(thr_t) * 34'(thr_t);
        end
    end

    // stage 1: radicands, differences, sums
    logic signed [CW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    assign r00 = CW'(in_data.el_00);
    assign r01 = CW'(in_data.el_01);
    assign r02 = CW'(in_data.el_02);
    assign r10 = CW'(in_data.el_10);
    assign r11 = CW'(in_data.el_11);
    assign r12 = CW'(in_data.el_12);
    assign r20 = CW'(in_data.el_20);
    assign r21 = CW'(in_data.el_21);
    assign r22 = CW'(in_data.el_22);

    logic                 s1_v_reg;
    logic signed [CW-1:0] rad0_reg, rad1_reg, rad2_reg, rad3_reg;
    logic signed [CW-1:0] d21_reg, d02_reg, d10_reg, s01_reg, s02_reg, s12_reg;
    logic                 domx_reg, domy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad0_reg <= ONE_S + r00 + r11 + r22;
            rad1_reg <= ONE_S + r00 - r11 - r22;
            rad2_reg <= ONE_S - r00 + r11 - r22;
            rad3_reg <= ONE_S - r00 - r11 + r22;
            d21_reg  <= r21 - r12;
            d02_reg  <= r02 - r20;
            d10_reg  <= r10 - r01;
            s01_reg  <= r01 + r10;
            s02_reg  <= r02 + r20;
            s12_reg  <= r12 + r21;
            domx_reg <= (r00 > r11) && (r00 > r22);
            domy_reg <= (r11 > r22);
        end
    end

    // stage 2: branch choice
    logic                     trace_sel;
    logic [2:0]               br_next;
    logic signed [3:0][CW-1:0] c_next;

    assign trace_sel = (rad0_reg > 0)
                    && ((rmq_pkg::KW'($unsigned(rad0_reg)) << rmq_pkg::F)
                        >= rmq_pkg::KW'(thr_sq_reg));

    always_comb
    begin
        if (trace_sel)
        begin
            br_next = rmq_pkg::BR_TRACE;
            c_next  = {rad0_reg, d21_reg, d02_reg, d10_reg};
        end
        else if (domx_reg)
        begin
            br_next = (rad1_reg > 0) ? rmq_pkg::BR_XDOM : rmq_pkg::BR_IDENT;
            c_next  = {d21_reg, rad1_reg, s01_reg, s02_reg};
        end
        else if (domy_reg)
        begin
            br_next = (rad2_reg > 0) ? rmq_pkg::BR_YDOM : rmq_pkg::BR_IDENT;
            c_next  = {d02_reg, s01_reg, rad2_reg, s12_reg};
        end
        else
        begin
            br_next = (rad3_reg > 0) ? rmq_pkg::BR_ZDOM : rmq_pkg::BR_IDENT;
            c_next  = {d10_reg, s02_reg, s12_reg, rad3_reg};
        end
    end

    logic                      s2_v_reg;
    logic signed [3:0][CW-1:0] c_reg;
    logic [2:0]                br_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg  <= c_next;
            br_reg <= br_next;
        end
    end

    // stage 3: magnitudes and squares
    rmq_pkg::carry_t           side_next;
    logic [3:0][rmq_pkg::MW-1:0] sq_next;

    always_comb
    begin
        side_next.branch = br_reg;
        for (int i = 0; i < 4; i++)
        begin
            side_next.neg[3-i] = c_reg[i][CW-1];
            side_next.mag[3-i] = (CW-1)'(c_reg[i][CW-1] ? -c_reg[i] : c_reg[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            sq_next[i] = rmq_pkg::MW'(side_next.mag[i]) * rmq_pkg::MW'(side_next.mag[i]);
        end
    end

    logic                        s3_v_reg;
    logic [3:0][rmq_pkg::MW-1:0] sq_reg;
    rmq_pkg::carry_t             s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg      <= sq_next;
            s3_side_reg <= side_next;
        end
    end

    // stage 4: sum of squares
    logic                   s4_v_reg;
    logic [rmq_pkg::SW-1:0] sum_reg;
    rmq_pkg::carry_t        s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_v_reg <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= rmq_pkg::SW'(sq_reg[0]) + rmq_pkg::SW'(sq_reg[1])
                     + rmq_pkg::SW'(sq_reg[2]) + rmq_pkg::SW'(sq_reg[3]);
            s4_side_reg <= s3_side_reg;
        end
    end

    logic                   sq_v;
    logic [rmq_pkg::NW-1:0] norm;
    rmq_pkg::carry_t        sq_side;

    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s4_v_reg),
        .in_sum    (sum_reg),
        .in_side   (s4_side_reg),
        .out_valid (sq_v),
        .out_root  (norm),
        .out_side  (sq_side)
    );

    logic                          dv_v;
    logic [3:0][rmq_pkg::QW-1:0]   quot;
    rmq_pkg::carry_t               dv_side;

    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_v),
        .in_norm   (norm),
        .in_side   (sq_side),
        .out_valid (dv_v),
        .out_quot  (quot),
        .out_side  (dv_side)
    );

    // final stage: saturate, sign, identity fallback
    logic [3:0][15:0] qo;

    always_comb
    begin
        logic [rmq_pkg::QW-1:0]       qs;
        logic signed [rmq_pkg::F+1:0] sv;
        qs = '0;
        sv = '0;
        for (int i = 0; i < 4; i++)
        begin
            qs = (quot[i] > rmq_pkg::QW'(rmq_pkg::ONE)) ? rmq_pkg::QW'(rmq_pkg::ONE) : quot[i];
            sv = $signed({1'b0, qs});
            if (dv_side.neg[i])
            begin
                sv = -sv;
            end
            qo[i] = 16'(sv);
        end
    end

    rmq_pkg::out_word_t res_next;

    always_comb
    begin
        res_next.branch_taken = dv_side.branch;
        if (dv_side.branch == rmq_pkg::BR_IDENT)
        begin
            res_next.quat_w = 16'(rmq_pkg::ONE);
            res_next.quat_x = '0;
            res_next.quat_y = '0;
            res_next.quat_z = '0;
        end
        else
        begin
            res_next.quat_w = qo[0];
            res_next.quat_x = qo[1];
            res_next.quat_y = qo[2];
            res_next.quat_z = qo[3];
        end
    end

    logic               res_v_reg;
    rmq_pkg::out_word_t res_reg;
    logic               skid_full_reg;
    rmq_pkg::out_word_t skid_reg;

    assign en        = !skid_full_reg;
    assign in_ready  = en;
    assign out_valid = skid_full_reg || res_v_reg;
    assign out_data  = skid_full_reg ? skid_reg : res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v_reg     <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                res_v_reg <= dv_v;
            end
            if (!skid_full_reg && res_v_reg && !out_ready)
            begin
                skid_full_reg <= 1'b1;
            end
            else if (skid_full_reg && out_ready)
            begin
                skid_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
        if (!skid_full_reg && res_v_reg && !out_ready)
        begin
            skid_reg <= res_reg;
        end
    end

    `RMQ_ASSERT_IMP(a_ident_word, clk, rst_n,
        out_valid && (out_data.branch_taken == rmq_pkg::BR_IDENT),
        (out_data.quat_w == 16'(rmq_pkg::ONE)) && (out_data.quat_x == 16'd0)
        && (out_data.quat_y == 16'd0) && (out_data.quat_z == 16'd0))
    `RMQ_ASSERT_NEXT(a_skid_fill, clk, rst_n,
        !skid_full_reg && res_v_reg && !out_ready,
        skid_full_reg && !in_ready)
    `RMQ_ASSERT_NEXT(a_thr_follow, clk, rst_n,
        1'b1,
        thr_sq_reg == 34'($past(thr_t)) * 34'($past(thr_t)))

endmodule

/* sv/rmq_sqrt.sv */
// pipelined integer square root, one root bit per stage
module rmq_sqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [rmq_pkg::SW-1:0]  in_sum,
    input  rmq_pkg::carry_t         in_side,
    output logic                    out_valid,
    output logic [rmq_pkg::NW-1:0]  out_root,
    output rmq_pkg::carry_t         out_side
);

    logic [rmq_pkg::NW-1:0] v_reg;
    logic [rmq_pkg::SW-1:0] rad_reg  [rmq_pkg::NW];
    logic [rmq_pkg::RW-1:0] rem_reg  [rmq_pkg::NW];
    logic [rmq_pkg::NW-1:0] root_reg [rmq_pkg::NW];
    rmq_pkg::carry_t        side_reg [rmq_pkg::NW];

    genvar k;
    for (k = 0; k < rmq_pkg::NW; k++)
    begin : g_stage
        logic                   v_in;
        logic [rmq_pkg::SW-1:0] rad_in;
        logic [rmq_pkg::RW-1:0] rem_in;
        logic [rmq_pkg::NW-1:0] root_in;
        rmq_pkg::carry_t        side_in;
        logic [rmq_pkg::RW-1:0] rem_sh;
        logic [rmq_pkg::RW-1:0] trial;
        logic                   take;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_sum;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign rem_sh = {rem_in[rmq_pkg::RW-3:0], rad_in[rmq_pkg::SW-1 -: 2]};
        assign trial  = {{(rmq_pkg::RW-rmq_pkg::NW-2){1'b0}}, root_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= take ? (rem_sh - trial) : rem_sh;
                root_reg[k] <= {root_in[rmq_pkg::NW-2:0], take};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[rmq_pkg::NW-1];
    assign out_root  = root_reg[rmq_pkg::NW-1];
    assign out_side  = side_reg[rmq_pkg::NW-1];

endmodule

/* sv/rmq_div.sv */
// four-lane pipelined restoring divider, one quotient bit per stage
module rmq_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [rmq_pkg::NW-1:0]        in_norm,
    input  rmq_pkg::carry_t               in_side,
    output logic                          out_valid,
    output logic [3:0][rmq_pkg::QW-1:0]   out_quot,
    output rmq_pkg::carry_t               out_side
);

    logic [rmq_pkg::QW:0]              v_reg;
    logic [rmq_pkg::NW-1:0]            n_reg    [rmq_pkg::QW+1];
    logic [3:0][rmq_pkg::DW-1:0]       rem_reg  [rmq_pkg::QW+1];
    logic [3:0][rmq_pkg::QW-1:0]       q_reg    [rmq_pkg::QW+1];
    rmq_pkg::carry_t                   side_reg [rmq_pkg::QW+1];

    logic [3:0][rmq_pkg::DW-1:0] num;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            num[i] = (rmq_pkg::DW'(in_side.mag[i]) << rmq_pkg::F)
                   + rmq_pkg::DW'(in_norm >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]    <= in_norm;
            rem_reg[0]  <= num;
            q_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    genvar k;
    for (k = 1; k <= rmq_pkg::QW; k++)
    begin : g_stage
        logic [rmq_pkg::DW-1:0]      dsh;
        logic [3:0][rmq_pkg::DW-1:0] rem_next;
        logic [3:0][rmq_pkg::QW-1:0] q_next;

        assign dsh = rmq_pkg::DW'(n_reg[k-1]) << (rmq_pkg::QW - k);

        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (rem_reg[k-1][i] >= dsh)
                begin
                    rem_next[i] = rem_reg[k-1][i] - dsh;
                    q_next[i]   = {q_reg[k-1][i][rmq_pkg::QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[i] = rem_reg[k-1][i];
                    q_next[i]   = {q_reg[k-1][i][rmq_pkg::QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k]    <= n_reg[k-1];
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[rmq_pkg::QW];
    assign out_quot  = q_reg[rmq_pkg::QW];
    assign out_side  = side_reg[rmq_pkg::QW];

endmodule
